FILE: design/mtrr_pkg.sv
package mtrr_pkg;

	// table size and address space
	localparam int MAX_RANGES = 16;
	localparam int PAGE_COUNT = 262144;

	// field widths
	localparam int FRAME_W    = 40;
	localparam int PAGE_W     = 18;
	localparam int TYPE_W     = 3;
	localparam int KIND_W     = 2;
	localparam int STORED_W   = 5;
	localparam int HUGE_SHIFT = 9;	// 4 KB frames per 2 MB page, log2

	// derived widths
	localparam int IDX_W   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W   = $clog2(MAX_RANGES + 1);
	localparam int PGC_W   = $clog2(PAGE_COUNT + 1);
	localparam int ENTRY_W = 2 * FRAME_W + TYPE_W;

	// stream widths
	localparam int S_DATA_W = 104;
	localparam int S_USER_W = KIND_W;
	localparam int M_DATA_W = 16;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	// memory types
	localparam logic [TYPE_W-1:0] TYPE_UC = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_WB = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clear;
		logic span;
		logic write;
		logic set_ovf;
		logic scan_init;
		logic scan_step;
		logic out_load;
	} mtrr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              load_ok;
		logic              full;
		logic              query_go;
		logic              scan_done;
		logic              out_free;
	} mtrr_stat_t;

endpackage

FILE: design/mtrr_ram.sv
module mtrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/mtrr_ctrl.sv
module mtrr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  mtrr_pkg::mtrr_stat_t stat,
	output mtrr_pkg::mtrr_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_WRITE  = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.kind)
					mtrr_pkg::KIND_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = S_DONE;
					end
					mtrr_pkg::KIND_LOAD: begin
						priority if (!stat.load_ok) begin
							state_d = S_DONE;
						end else if (stat.full) begin
							cmd.set_ovf = 1'b1;
							state_d     = S_DONE;
						end else begin
							cmd.span = 1'b1;
							state_d  = S_WRITE;
						end
					end
					mtrr_pkg::KIND_QUERY: begin
						cmd.scan_init = 1'b1;
						state_d       = stat.query_go ? S_SCAN : S_DONE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: design/mtrr_dp.sv
module mtrr_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [mtrr_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic [mtrr_pkg::S_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mtrr_pkg::M_DATA_W-1:0]   m_tdata,
	input  mtrr_pkg::mtrr_cmd_t             cmd,
	output mtrr_pkg::mtrr_stat_t            stat
);

	// captured word
	logic [mtrr_pkg::KIND_W-1:0]  kind_q;
	logic [mtrr_pkg::FRAME_W-1:0] base_q;
	logic [mtrr_pkg::FRAME_W-1:0] mask_q;
	logic                         valid_q;
	logic [mtrr_pkg::TYPE_W-1:0]  type_q;
	logic [mtrr_pkg::PAGE_W-1:0]  page_q;

	// working state
	logic [mtrr_pkg::FRAME_W-1:0] span_q;
	logic [mtrr_pkg::CNT_W-1:0]   cnt_q;
	logic [mtrr_pkg::IDX_W-1:0]   idx_q;
	logic [mtrr_pkg::TYPE_W-1:0]  mem_q;
	logic                         ovf_q;

	// output register
	logic                          out_valid_q;
	logic [mtrr_pkg::TYPE_W-1:0]   out_mem_q;
	logic [mtrr_pkg::STORED_W-1:0] out_cnt_q;
	logic                          out_ovf_q;

	// table port
	logic [mtrr_pkg::IDX_W-1:0]   raddr;
	logic [mtrr_pkg::ENTRY_W-1:0] rdata;
	logic [mtrr_pkg::ENTRY_W-1:0] wdata;

	// load arithmetic
	logic [mtrr_pkg::FRAME_W:0]   end_sum;
	logic [mtrr_pkg::FRAME_W-1:0] last_f;

	// scan compare
	logic [mtrr_pkg::FRAME_W-1:0] ent_start;
	logic [mtrr_pkg::FRAME_W-1:0] ent_last;
	logic [mtrr_pkg::TYPE_W-1:0]  ent_type;
	logic [mtrr_pkg::FRAME_W-1:0] page_first;
	logic [mtrr_pkg::FRAME_W-1:0] page_end;
	logic                         hit;
	logic                         last_idx;
	logic                         page_ok;

	// range end from base and span, saturated at the top frame
	assign end_sum = {1'b0, base_q} + {1'b0, span_q};
	assign last_f  = end_sum[mtrr_pkg::FRAME_W] ? '1 : end_sum[mtrr_pkg::FRAME_W-1:0];
	assign wdata   = {type_q, last_f, base_q};

	// entry read for the scan, next index prefetched
	assign raddr = cmd.scan_step ? (idx_q + mtrr_pkg::IDX_W'(1)) : '0;

	mtrr_ram #(
		.WIDTH(mtrr_pkg::ENTRY_W),
		.DEPTH(mtrr_pkg::MAX_RANGES)
	) u_table (
		.clk  (clk),
		.we   (cmd.write),
		.waddr(cnt_q[mtrr_pkg::IDX_W-1:0]),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// overlap test in frame units
	assign ent_start  = rdata[mtrr_pkg::FRAME_W-1:0];
	assign ent_last   = rdata[2*mtrr_pkg::FRAME_W-1:mtrr_pkg::FRAME_W];
	assign ent_type   = rdata[mtrr_pkg::ENTRY_W-1:2*mtrr_pkg::FRAME_W];
	assign page_first = mtrr_pkg::FRAME_W'({page_q, {mtrr_pkg::HUGE_SHIFT{1'b0}}});
	assign page_end   = mtrr_pkg::FRAME_W'({page_q, {mtrr_pkg::HUGE_SHIFT{1'b1}}});
	assign hit        = (page_first <= ent_last) && (page_end >= ent_start);
	assign last_idx   = ((mtrr_pkg::CNT_W'(idx_q) + mtrr_pkg::CNT_W'(1)) == cnt_q);
	assign page_ok    = ({1'b0, page_q} < mtrr_pkg::PGC_W'(mtrr_pkg::PAGE_COUNT));

	// status
	assign stat.kind      = kind_q;
	assign stat.load_ok   = valid_q && (type_q != mtrr_pkg::TYPE_WB);
	assign stat.full      = (cnt_q >= mtrr_pkg::CNT_W'(mtrr_pkg::MAX_RANGES));
	assign stat.query_go  = page_ok && (cnt_q != '0);
	assign stat.scan_done = (hit && (ent_type == mtrr_pkg::TYPE_UC)) || last_idx;
	assign stat.out_free  = !out_valid_q || m_tready;

	// input word capture and per-item work registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= s_tuser;
			base_q  <= s_tdata[39:0];
			mask_q  <= s_tdata[79:40];
			valid_q <= s_tdata[80];
			type_q  <= s_tdata[83:81];
			page_q  <= s_tdata[101:84];
			mem_q   <= mtrr_pkg::TYPE_WB;
			ovf_q   <= 1'b0;
		end
		// span is lowest set mask bit minus one, all ones for a zero mask
		if (cmd.span) begin
			span_q <= (mask_q & (~mask_q + mtrr_pkg::FRAME_W'(1))) - mtrr_pkg::FRAME_W'(1);
		end
		if (cmd.set_ovf) begin
			ovf_q <= 1'b1;
		end
		if (cmd.scan_init) begin
			idx_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + mtrr_pkg::IDX_W'(1);
		end
		if (cmd.scan_step && hit) begin
			mem_q <= ent_type;
		end
	end

	// range count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
		end else if (cmd.write) begin
			cnt_q <= cnt_q + mtrr_pkg::CNT_W'(1);
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_mem_q <= mem_q;
			out_cnt_q <= mtrr_pkg::STORED_W'(cnt_q);
			out_ovf_q <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_ovf_q, out_cnt_q, out_mem_q};

endmodule

FILE: design/mtrr_memory_type_resolver.sv
// steps: accept, decode, then a table write for a load that stores a range, or a table scan
//   for a query whose page is in range while ranges are stored (up to 16 scanned), then the
//   output register; the scan reads one table entry per cycle and stops at an uncacheable hit
// input is accepted only in the idle state, after the previous result is loaded for output
// the next word is taken while the previous result still waits on the output register
// reset: arst_n clears the range count, the controller state and the output valid
module mtrr_memory_type_resolver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// base_frame[39:0], mask_frame[79:40], range_valid[80], range_type[83:81],
	// page_index[101:84], zero fill
	input  logic [mtrr_pkg::S_DATA_W-1:0] s_tdata,
	// kind[1:0]
	input  logic [mtrr_pkg::S_USER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// mem_type[2:0], stored_ranges[7:3], overflow[8], zero fill
	output logic [mtrr_pkg::M_DATA_W-1:0] m_tdata
);

	mtrr_pkg::mtrr_cmd_t  cmd;
	mtrr_pkg::mtrr_stat_t stat;

	// sequencer
	mtrr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// range table and compare logic
	mtrr_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

FILE: design/mtrr_chk.sv
module mtrr_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mtrr_pkg::M_DATA_W-1:0] m_tdata
);

	// a stalled output word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// the count never exceeds the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:3] <= mtrr_pkg::MAX_RANGES)
		else $error("stored range count above table size");

	// an overflow word reports a full table and the default type
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |->
		m_tdata[7:3] == mtrr_pkg::STORED_W'(mtrr_pkg::MAX_RANGES) &&
		m_tdata[2:0] == mtrr_pkg::TYPE_WB)
		else $error("overflow with a table that is not full");

	// no new word is taken in the cycle right after one was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on back-to-back cycles");

endmodule

bind mtrr_memory_type_resolver mtrr_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

FILE: test/mtrr_result_checker.sv
module mtrr_result_checker
	import mtrr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	// base_frame[39:0], mask_frame[79:40], range_valid[80], range_type[83:81],
	// page_index[101:84], zero fill
	input  logic [S_DATA_W-1:0] s_tdata,
	// kind[1:0]
	input  logic [S_USER_W-1:0] s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	// mem_type[2:0], stored_ranges[7:3], overflow[8], zero fill
	input  logic [M_DATA_W-1:0] m_tdata,
	output int                  errors,
	output int                  pending,
	output int                  compared
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_W          = 52;
	localparam int PAGE_BYTE_SHIFT = HUGE_SHIFT + 12;

	typedef struct packed {
		logic [TYPE_W-1:0]   mem_type;
		logic [STORED_W-1:0] stored;
		logic                ovf;
	} outcome_t;

	// own copy of the range table
	logic [ADDR_W-1:0] span_lo [MAX_RANGES];
	logic [ADDR_W-1:0] span_hi [MAX_RANGES];
	logic [TYPE_W-1:0] span_type [MAX_RANGES];
	int                span_count;

	outcome_t expected_words[$];

	// index of the lowest set bit, a zero mask covers the whole space
	function automatic int low_one(input logic [ADDR_W-1:0] v);
		for (int i = 0; i < ADDR_W; i++) begin
			if (v[i])
				return i;
		end
		return ADDR_W;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// update the table for one accepted word and queue its answer
	task automatic resolve_word(input logic [S_USER_W-1:0] kind,
			input logic [S_DATA_W-1:0] data);
		logic [ADDR_W-1:0] base_addr;
		logic [ADDR_W-1:0] mask_addr;
		logic [ADDR_W-1:0] lo_addr;
		logic [ADDR_W-1:0] hi_addr;
		logic [ADDR_W:0]   sum;
		logic [PAGE_W-1:0] page;
		logic [TYPE_W-1:0] mtype;
		logic              vld;
		outcome_t          res;
		int                k;
		base_addr    = {data[39:0], 12'h000};
		mask_addr    = {data[79:40], 12'h000};
		vld          = data[80];
		mtype        = data[83:81];
		page         = data[101:84];
		res.mem_type = TYPE_WB;
		res.ovf      = 1'b0;
		case (kind)
			KIND_CLEAR: begin
				span_count = 0;
			end
			KIND_LOAD: begin
				if (vld && mtype != TYPE_WB) begin
					if (span_count >= MAX_RANGES) begin
						res.ovf = 1'b1;
					end else begin
						k   = low_one(mask_addr);
						sum = {1'b0, base_addr} + (((ADDR_W+1)'(1) << k) - (ADDR_W+1)'(1));
						// end saturates at the top of the address space
						span_lo[span_count]   = base_addr;
						span_hi[span_count]   = sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
						span_type[span_count] = mtype;
						span_count++;
					end
				end
			end
			KIND_QUERY: begin
				if (int'(page) < PAGE_COUNT) begin
					lo_addr = ADDR_W'(page) << PAGE_BYTE_SHIFT;
					hi_addr = lo_addr + ((ADDR_W'(1) << PAGE_BYTE_SHIFT) - ADDR_W'(1));
					// last overlap wins, uncacheable ends the scan
					for (int i = 0; i < span_count; i++) begin
						if (lo_addr <= span_hi[i] && hi_addr >= span_lo[i]) begin
							res.mem_type = span_type[i];
							if (res.mem_type == TYPE_UC)
								break;
						end
					end
				end
			end
			default: begin
			end
		endcase
		res.stored = STORED_W'(span_count);
		expected_words.push_back(res);
	endtask

	// compare one result word with the oldest expectation
	task automatic check_word(input logic [M_DATA_W-1:0] word);
		outcome_t want;
		if (expected_words.size() == 0) begin
			report_mismatch("unexpected result word", int'(word), 0);
		end else begin
			want = expected_words.pop_front();
			compared++;
			if (word[2:0] !== want.mem_type)
				report_mismatch("mem_type", int'(word[2:0]), int'(want.mem_type));
			if (word[7:3] !== want.stored)
				report_mismatch("stored_ranges", int'(word[7:3]), int'(want.stored));
			if (word[8] !== want.ovf)
				report_mismatch("overflow", int'(word[8]), int'(want.ovf));
		end
	endtask

	// watch both channels, input side first
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_count = 0;
			expected_words.delete();
		end else begin
			if (s_tvalid && s_tready)
				resolve_word(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				check_word(m_tdata);
		end
		pending <= expected_words.size();
	end

endmodule

FILE: test/mtrr_memory_type_resolver_tb.sv
module mtrr_memory_type_resolver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtrr_pkg::*;

	// kind value the block leaves unused
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 650;
	localparam int PAGE_MAX = PAGE_COUNT - 1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	int   errors;
	int   pending;
	int   compared;
	int   words_sent = 0;
	int   kind_seen[4] = '{0, 0, 0, 0};
	int   stall_left = 0;
	logic quiet = 1'b0;

	mtrr_memory_type_resolver i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	mtrr_result_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending),
		.compared (compared)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	// receiver stalls, mostly short, a few long, none started while quiet
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < 25) begin
			m_tready   <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic [FRAME_W-1:0] rnd_frame();
		return FRAME_W'({$urandom(), $urandom()});
	endfunction

	// random mask whose lowest set bit is j, zero mask for j past the field
	function automatic logic [FRAME_W-1:0] mask_with_low(input int j);
		logic [FRAME_W-1:0] m;
		m = rnd_frame();
		if (j >= FRAME_W)
			return '0;
		m    = m & ~((FRAME_W'(1) << j) - FRAME_W'(1));
		m[j] = 1'b1;
		return m;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// present one word, wait for the handshake, then maybe pause
	task automatic send_word(input logic [KIND_W-1:0] kind, input logic [FRAME_W-1:0] base,
			input logic [FRAME_W-1:0] mask, input logic vld, input logic [TYPE_W-1:0] mtype,
			input logic [PAGE_W-1:0] page);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, page, mtype, vld, mask, base};
		do
			@(posedge clk);
		while (!s_tready);
		words_sent++;
		kind_seen[kind]++;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_clear();
		send_word(KIND_CLEAR, rnd_frame(), rnd_frame(), 1'($urandom()), 3'($urandom()),
			18'($urandom()));
	endtask

	task automatic send_load(input logic [FRAME_W-1:0] base, input logic [FRAME_W-1:0] mask,
			input logic vld, input logic [TYPE_W-1:0] mtype);
		send_word(KIND_LOAD, base, mask, vld, mtype, 18'($urandom()));
	endtask

	task automatic send_query(input logic [PAGE_W-1:0] page);
		send_word(KIND_QUERY, rnd_frame(), rnd_frame(), 1'($urandom()), 3'($urandom()), page);
	endtask

	// range near the low pages so that queries hit it
	task automatic send_random_load();
		logic [FRAME_W-1:0] base;
		int                 j;
		int                 r;
		base = FRAME_W'($urandom_range(0, 63)) << HUGE_SHIFT;
		if ($urandom_range(0, 3) == 0)
			base = base + FRAME_W'($urandom_range(0, 511));
		if ($urandom_range(0, 9) == 0)
			base = rnd_frame();
		r = $urandom_range(0, 19);
		if (r == 0)
			j = FRAME_W;
		else if (r == 1)
			j = $urandom_range(0, FRAME_W - 1);
		else
			j = $urandom_range(0, 14);
		send_load(base, mask_with_low(j), $urandom_range(0, 9) != 0, 3'($urandom_range(0, 7)));
	endtask

	// hold the sender until every answer is back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		int seq;
		int start_count;
		int pg;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, ignored loads, zero mask, saturated end, uncacheable
		send_clear();
		send_query('0);
		send_query(PAGE_W'(PAGE_MAX));
		send_load(40'd1024, 40'd512, 1'b0, 3'd1);
		send_load(40'd1024, 40'd512, 1'b1, TYPE_WB);
		send_load('0, '0, 1'b1, 3'd5);
		send_load('1, 40'h80_0000_0000, 1'b1, 3'd4);
		send_load(40'd1536, 40'hFF_FFFF_FE00, 1'b1, TYPE_UC);
		send_query(18'd3);
		send_query(18'd4);
		send_word(KIND_SPARE, rnd_frame(), rnd_frame(), 1'b1, 3'd7, '1);
		// fill the table, then overflow and an ignored load while full
		for (int i = 0; i < MAX_RANGES - 3; i++)
			send_load(FRAME_W'(10 + i) << HUGE_SHIFT, mask_with_low(HUGE_SHIFT), 1'b1,
				3'(i % 6));
		send_load(40'd0, 40'd1, 1'b1, 3'd2);
		send_load(40'd0, 40'd1, 1'b0, 3'd2);
		send_query(18'd12);
		send_clear();
		wait_idle();

		// random: mostly clear, loads, queries; some noise
		seq         = 0;
		start_count = words_sent;
		while (words_sent - start_count < RANDOM_WORDS) begin
			seq++;
			if (seq % 7 == 0)
				quiet <= ~quiet;
			if (seq == 20)
				wait_idle();
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6))
					send_word(KIND_W'($urandom_range(0, 3)), rnd_frame(), rnd_frame(),
						1'($urandom()), 3'($urandom()), PAGE_W'($urandom_range(0, PAGE_MAX)));
			end else begin
				// sometimes keep the table so it fills up and overflows
				if ($urandom_range(0, 5) != 0)
					send_clear();
				repeat ($urandom_range(0, 20))
					send_random_load();
				repeat ($urandom_range(2, 8)) begin
					pg = ($urandom_range(0, 5) == 0) ? $urandom_range(0, PAGE_MAX)
						: $urandom_range(0, 63);
					send_query(PAGE_W'(pg));
				end
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		$display("covered %0d words: %0d clears, %0d loads, %0d queries, %0d unused kinds",
			words_sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		$display("%0d result words checked with random stalls on both sides", compared);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/mtrr_pkg.sv
design/mtrr_ram.sv
design/mtrr_ctrl.sv
design/mtrr_dp.sv
design/mtrr_memory_type_resolver.sv
design/mtrr_chk.sv
test/mtrr_result_checker.sv
test/mtrr_memory_type_resolver_tb.sv
